[hw/rtl/ehfx_pkg.sv]
// ehfx_pkg: shared types and constants for the ethernet header field extractor
// holds the input and result word types, the frame record passed front to back,
// frame kinds and header offsets; no dependencies
`timescale 1ns / 1ps

package ehfx_pkg;

    // header window kept per frame: bytes 12 to 41
    localparam int HdrFirst = 12;
    localparam int HdrDepth = 30;
    localparam int CountMax = 42;
    localparam int CountW   = 6;
    localparam int HdrIdxW  = 5;

    // minimum frame lengths for each check
    localparam int MinEth   = 14;
    localparam int MinIp4   = 34;
    localparam int MinTcp   = 38;
    localparam int MinArp   = 42;

    // ethertypes and protocol
    localparam logic [15:0] EtArp    = 16'h0806;
    localparam logic [15:0] EtIp4    = 16'h0800;
    localparam logic [15:0] EtIp6    = 16'h86DD;
    localparam logic [7:0]  ProtoTcp = 8'h06;

    // queue between front and back
    localparam int QDepth = 2;
    localparam int QPtrW  = 1;
    localparam int QCntW  = 2;

    // configuration register map
    localparam int PaddrW = 3;
    localparam logic [0:0] RegVerbose = 1'b0;

    typedef enum logic [2:0] {
        KIND_ARP     = 3'd0,
        KIND_ARP_BAD = 3'd1,
        KIND_IP4     = 3'd2,
        KIND_IP4_BAD = 3'd3,
        KIND_IP6     = 3'd4,
        KIND_OTHER   = 3'd5,
        KIND_RUNT    = 3'd6
    } frame_kind_t;

    typedef enum logic [1:0] {
        TCP_NONE = 2'd0,
        TCP_OK   = 2'd1,
        TCP_BAD  = 2'd2
    } tcp_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        frame_kind_t  frame_kind;
        logic [15:0]  ether_type;
        logic [47:0]  arp_sha;
        logic [47:0]  arp_tha;
        logic [31:0]  first_ip;
        logic [31:0]  second_ip;
        logic [5:0]   ip_hdr_bytes;
        logic [15:0]  ip_payload_len;
        logic [7:0]   ip_proto;
        tcp_status_t  tcp_status;
        logic [15:0]  tcp_sport;
        logic [15:0]  tcp_dport;
    } out_word_t;

    // one finished frame: saturated length and its header window
    typedef struct packed {
        logic [CountW-1:0]              size;
        logic [HdrDepth-1:0][7:0]       hdr;
    } frame_rec_t;

endpackage

[hw/rtl/ehfx_front.sv]
// ehfx_front: byte counter and header window capture
// pushes one frame record per final byte; depends on ehfx_pkg
`timescale 1ns / 1ps

module ehfx_front
    import ehfx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_data,
    output logic       push,
    output frame_rec_t push_rec,
    input  logic       q_full
);

    logic [CountW-1:0]        count_reg;
    logic [CountW-1:0]        count_next;
    logic [HdrDepth-1:0][7:0] hdr_reg;
    logic [HdrDepth-1:0][7:0] hdr_view;
    logic [CountW-1:0]        size;
    logic [HdrIdxW-1:0]       idx;
    logic                     accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign idx      = HdrIdxW'(count_reg - CountW'(HdrFirst));

    // header window with the incoming byte merged in
    always_comb
    begin
        hdr_view = hdr_reg;
        if (count_reg >= CountW'(HdrFirst) && count_reg < CountW'(CountMax))
        begin
            hdr_view[idx] = in_data.data_byte;
        end
    end

    // saturating length including this byte
    always_comb
    begin
        if (count_reg < CountW'(CountMax))
        begin
            size = count_reg + CountW'(1);
        end
        else
        begin
            size = count_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = in_data.last_byte ? '0 : size;
        end
    end

    assign push          = accept && in_data.last_byte;
    assign push_rec.size = size;
    assign push_rec.hdr  = hdr_view;

    // counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // header window storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg <= hdr_view;
        end
    end

endmodule

[hw/rtl/ehfx_queue.sv]
// ehfx_queue: two-entry queue of frame records between front and back
// depends on ehfx_pkg
`timescale 1ns / 1ps

module ehfx_queue
    import ehfx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_rec,
    output logic       full,
    input  logic       pop,
    output logic       q_valid,
    output frame_rec_t head
);

    frame_rec_t           mem_reg [QDepth];
    logic [QPtrW-1:0]     wr_ptr_reg;
    logic [QPtrW-1:0]     rd_ptr_reg;
    logic [QCntW-1:0]     cnt_reg;
    logic [QCntW-1:0]     cnt_next;

    assign full    = cnt_reg == QCntW'(QDepth);
    assign q_valid = cnt_reg != '0;
    assign head    = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCntW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCntW'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[hw/rtl/ehfx_back.sv]
// ehfx_back: frame classification, field extraction and the result register
// pops one frame record per cycle when the output can take it; depends on ehfx_pkg
`timescale 1ns / 1ps

module ehfx_back
    import ehfx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       verbose,
    input  logic       q_valid,
    input  frame_rec_t head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_data
);

    logic               out_valid_reg;
    out_word_t          out_data_reg;
    out_word_t          out_next;
    logic [15:0]        et;
    logic [5:0]         hlen;
    logic [15:0]        total;
    logic [7:0]         proto;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // header fields at fixed offsets (window starts at byte 12)
    assign et    = {head.hdr[12 - HdrFirst], head.hdr[13 - HdrFirst]};
    assign hlen  = {head.hdr[14 - HdrFirst][3:0], 2'b00};
    assign total = {head.hdr[16 - HdrFirst], head.hdr[17 - HdrFirst]};
    assign proto = head.hdr[23 - HdrFirst];

    // classify and extract
    always_comb
    begin
        out_next = '0;
        out_next.frame_kind = KIND_RUNT;
        out_next.tcp_status = TCP_NONE;
        if (head.size >= CountW'(MinEth))
        begin
            out_next.ether_type = et;
            if (et == EtArp)
            begin
                if (head.size < CountW'(MinArp))
                begin
                    out_next.frame_kind = KIND_ARP_BAD;
                end
                else
                begin
                    out_next.frame_kind = KIND_ARP;
                    out_next.arp_sha    = {head.hdr[22 - HdrFirst], head.hdr[23 - HdrFirst],
                                           head.hdr[24 - HdrFirst], head.hdr[25 - HdrFirst],
                                           head.hdr[26 - HdrFirst], head.hdr[27 - HdrFirst]};
                    out_next.arp_tha    = {head.hdr[32 - HdrFirst], head.hdr[33 - HdrFirst],
                                           head.hdr[34 - HdrFirst], head.hdr[35 - HdrFirst],
                                           head.hdr[36 - HdrFirst], head.hdr[37 - HdrFirst]};
                    out_next.first_ip   = {head.hdr[28 - HdrFirst], head.hdr[29 - HdrFirst],
                                           head.hdr[30 - HdrFirst], head.hdr[31 - HdrFirst]};
                    out_next.second_ip  = {head.hdr[38 - HdrFirst], head.hdr[39 - HdrFirst],
                                           head.hdr[40 - HdrFirst], head.hdr[41 - HdrFirst]};
                end
            end
            else if (et == EtIp4)
            begin
                if (head.size < CountW'(MinIp4))
                begin
                    out_next.frame_kind = KIND_IP4_BAD;
                end
                else
                begin
                    out_next.frame_kind     = KIND_IP4;
                    out_next.first_ip       = {head.hdr[26 - HdrFirst], head.hdr[27 - HdrFirst],
                                               head.hdr[28 - HdrFirst], head.hdr[29 - HdrFirst]};
                    out_next.second_ip      = {head.hdr[30 - HdrFirst], head.hdr[31 - HdrFirst],
                                               head.hdr[32 - HdrFirst], head.hdr[33 - HdrFirst]};
                    out_next.ip_hdr_bytes   = hlen;
                    out_next.ip_payload_len = total - {10'b0, hlen};
                    out_next.ip_proto       = proto;
                    if (verbose && proto == ProtoTcp)
                    begin
                        if (head.size < CountW'(MinTcp))
                        begin
                            out_next.tcp_status = TCP_BAD;
                        end
                        else
                        begin
                            out_next.tcp_status = TCP_OK;
                            out_next.tcp_sport  = {head.hdr[34 - HdrFirst],
                                                   head.hdr[35 - HdrFirst]};
                            out_next.tcp_dport  = {head.hdr[36 - HdrFirst],
                                                   head.hdr[37 - HdrFirst]};
                        end
                    end
                end
            end
            else if (et == EtIp6)
            begin
                out_next.frame_kind = KIND_IP6;
            end
            else
            begin
                out_next.frame_kind = KIND_OTHER;
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_next;
        end
    end

endmodule

[hw/rtl/ethernet_header_field_extractor.sv]
// ethernet_header_field_extractor: one frame byte per word in, one summary word per frame out
// throughput: one byte per cycle while the record queue is not full; a frame's record is
// written to the queue with its last byte, then decoded into the result register; the
// two-entry queue lets the byte side keep running while a summary waits on out_ready
// reset: asynchronous active low; clears the byte count, queue, result valid and verbose
// depends on ehfx_pkg, ehfx_front, ehfx_queue, ehfx_back
`timescale 1ns / 1ps

module ethernet_header_field_extractor
    import ehfx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [PaddrW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic       verbose_reg;
    logic       push;
    frame_rec_t push_rec;
    logic       q_full;
    logic       pop;
    logic       q_valid;
    frame_rec_t head;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[PaddrW-1] == RegVerbose) ? {31'b0, verbose_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verbose_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[PaddrW-1] == RegVerbose)
        begin
            verbose_reg <= pwdata[0];
        end
    end

    // byte side
    ehfx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .push     (push),
        .push_rec (push_rec),
        .q_full   (q_full)
    );

    // record queue
    ehfx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    // summary side
    ehfx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .verbose   (verbose_reg),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for ethernet_header_field_extractor, frames in, summaries out
// a scoreboard class predicts each frame summary from the accepted bytes; tasks drive
// the byte stream, the summary side and the register port. depends on ehfx_pkg and the rtl
`timescale 1ns / 1ps

module tb_top
    import ehfx_pkg::*;
();

    // register index with no register behind it, writes are dropped
    localparam int RegSpare = 1;

    typedef enum int {PICK_ARP, PICK_IP4, PICK_IP6, PICK_RANDOM} frame_pick_t;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    // predicts one summary per frame and checks summaries in order
    class frame_scoreboard;
        bit         verbose;
        int         byte_count;
        logic [7:0] hdr [HdrDepth];
        out_word_t  pending_summaries [$];
        int         errors;

        function void set_register(int index, logic [31:0] value);
            if (index == int'(RegVerbose))
                verbose = value[0];
        endfunction

        function logic [63:0] field_be(int off, int n);
            logic [63:0] v;
            int k;
            v = '0;
            for (k = 0; k < n; k++)
                v = {v[55:0], hdr[off + k - HdrFirst]};
            return v;
        endfunction

        function out_word_t summarize_frame(int size);
            out_word_t   s;
            logic [15:0] et;
            logic [5:0]  hlen;
            logic [15:0] total;
            s = '0;
            if (size < MinEth)
            begin
                s.frame_kind = KIND_RUNT;
                return s;
            end
            et = 16'(field_be(12, 2));
            s.ether_type = et;
            if (et == EtArp)
            begin
                if (size < MinArp)
                begin
                    s.frame_kind = KIND_ARP_BAD;
                    return s;
                end
                s.frame_kind = KIND_ARP;
                s.arp_sha    = 48'(field_be(22, 6));
                s.arp_tha    = 48'(field_be(32, 6));
                s.first_ip   = 32'(field_be(28, 4));
                s.second_ip  = 32'(field_be(38, 4));
            end
            else if (et == EtIp4)
            begin
                if (size < MinIp4)
                begin
                    s.frame_kind = KIND_IP4_BAD;
                    return s;
                end
                s.frame_kind     = KIND_IP4;
                hlen             = {hdr[14 - HdrFirst][3:0], 2'b00};
                total            = 16'(field_be(16, 2));
                s.first_ip       = 32'(field_be(26, 4));
                s.second_ip      = 32'(field_be(30, 4));
                s.ip_hdr_bytes   = hlen;
                s.ip_payload_len = total - {10'b0, hlen};
                s.ip_proto       = hdr[23 - HdrFirst];
                // ports only with verbose on and a tcp protocol byte
                if (verbose && s.ip_proto == ProtoTcp)
                begin
                    if (size < MinTcp)
                        s.tcp_status = TCP_BAD;
                    else
                    begin
                        s.tcp_status = TCP_OK;
                        s.tcp_sport  = 16'(field_be(34, 2));
                        s.tcp_dport  = 16'(field_be(36, 2));
                    end
                end
            end
            else if (et == EtIp6)
                s.frame_kind = KIND_IP6;
            else
                s.frame_kind = KIND_OTHER;
            return s;
        endfunction

        // count saturates at the end of the header window
        function void note_byte(in_word_t w);
            if (byte_count < CountMax)
            begin
                if (byte_count >= HdrFirst)
                    hdr[byte_count - HdrFirst] = w.data_byte;
                byte_count++;
            end
            if (w.last_byte)
            begin
                pending_summaries.push_back(summarize_frame(byte_count));
                byte_count = 0;
            end
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (got_v !== exp_v)
            begin
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_summary(out_word_t got);
            out_word_t exp_s;
            if (pending_summaries.size() == 0)
            begin
                $error("summary word with no frame pending");
                errors++;
                return;
            end
            exp_s = pending_summaries.pop_front();
            compare_field("frame_kind", 64'(exp_s.frame_kind), 64'(got.frame_kind));
            compare_field("ether_type", 64'(exp_s.ether_type), 64'(got.ether_type));
            compare_field("arp_sha", 64'(exp_s.arp_sha), 64'(got.arp_sha));
            compare_field("arp_tha", 64'(exp_s.arp_tha), 64'(got.arp_tha));
            compare_field("first_ip", 64'(exp_s.first_ip), 64'(got.first_ip));
            compare_field("second_ip", 64'(exp_s.second_ip), 64'(got.second_ip));
            compare_field("ip_hdr_bytes", 64'(exp_s.ip_hdr_bytes), 64'(got.ip_hdr_bytes));
            compare_field("ip_payload_len", 64'(exp_s.ip_payload_len),
                          64'(got.ip_payload_len));
            compare_field("ip_proto", 64'(exp_s.ip_proto), 64'(got.ip_proto));
            compare_field("tcp_status", 64'(exp_s.tcp_status), 64'(got.tcp_status));
            compare_field("tcp_sport", 64'(exp_s.tcp_sport), 64'(got.tcp_sport));
            compare_field("tcp_dport", 64'(exp_s.tcp_dport), 64'(got.tcp_dport));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_word_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_word_t         out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PaddrW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    frame_scoreboard sb = new();
    bit hold_off_req;
    bit no_gaps;
    int bytes_sent;

    ethernet_header_field_extractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watch both handshakes at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(in_data);
            if (out_valid && out_ready)
                sb.check_summary(out_data);
        end
    end

    // summary side: random stalls, one long hold-off on request
    initial
    begin
        int r;
        int len;
        bit level;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_off_req)
            begin
                level = 1'b0;
                len = 400;
                hold_off_req = 1'b0;
            end
            else if (r < 45)
            begin
                level = 1'b1;
                len = $urandom_range(1, 20);
            end
            else if (r < 52)
            begin
                level = 1'b1;
                len = $urandom_range(100, 200);
            end
            else if (r < 85)
            begin
                level = 1'b0;
                len = $urandom_range(1, 3);
            end
            else if (r < 96)
            begin
                level = 1'b0;
                len = $urandom_range(4, 12);
            end
            else
            begin
                level = 1'b0;
                len = $urandom_range(30, 80);
            end
            out_ready <= level;
            repeat (len) @(posedge clk);
        end
    end

    // mostly short gaps, a few long ones
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offer one word and hold it until taken
    task automatic send_word(input in_word_t w, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        bytes_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // build a frame of the given length and stream it out
    task automatic send_frame(input int len, input frame_pick_t pick, input bit tcp,
                              input fill_t fill, input bit short_total);
        logic [7:0] fr [];
        logic [15:0] et;
        in_word_t w;
        int i;
        fr = new[len];
        for (i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO: fr[i] = 8'h00;
                FILL_ONES: fr[i] = 8'hff;
                default:   fr[i] = 8'($urandom_range(0, 255));
            endcase
        end
        case (pick)
            PICK_ARP: et = EtArp;
            PICK_IP4: et = EtIp4;
            PICK_IP6: et = EtIp6;
            default:  et = len > 13 ? {fr[12], fr[13]} : 16'h0000;
        endcase
        if (len > 13)
        begin
            fr[12] = et[15:8];
            fr[13] = et[7:0];
        end
        if (tcp && len > 23)
            fr[23] = ProtoTcp;
        // largest header length over a tiny total length, so the payload length wraps unless the total is 60 or more
        if (short_total && len > 17)
        begin
            fr[14][3:0] = 4'hf;
            fr[16] = 8'h00;
            fr[17] = 8'($urandom_range(0, 63));
        end
        for (i = 0; i < len; i++)
        begin
            w.data_byte = fr[i];
            w.last_byte = (i == len - 1);
            send_word(w, sender_gap());
        end
    endtask

    task automatic random_frame();
        int r;
        int len;
        frame_pick_t pick;
        fill_t fill;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            case ($urandom_range(0, 9))
                0: len = 1;
                1: len = 13;
                2: len = 14;
                3: len = 33;
                4: len = 34;
                5: len = 37;
                6: len = 38;
                7: len = 41;
                8: len = 42;
                default: len = 43;
            endcase
        end
        else if (r < 80)
            len = $urandom_range(14, 48);
        else if (r < 95)
            len = $urandom_range(1, 13);
        else
            len = $urandom_range(49, 120);
        r = $urandom_range(0, 99);
        if (r < 35)
            pick = PICK_IP4;
        else if (r < 65)
            pick = PICK_ARP;
        else if (r < 75)
            pick = PICK_IP6;
        else
            pick = PICK_RANDOM;
        r = $urandom_range(0, 99);
        fill = r < 3 ? FILL_ZERO : (r < 6 ? FILL_ONES : FILL_RANDOM);
        no_gaps = ($urandom_range(0, 4) == 0);
        send_frame(len, pick, $urandom_range(0, 9) < 6, fill, $urandom_range(0, 9) < 2);
        no_gaps = 1'b0;
    endtask

    // let every pending summary drain before touching a register
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_summaries.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // setup cycle then access cycle
    task automatic write_reg(input int index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PaddrW'(index * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(index, value);
    endtask

    // main stimulus
    initial
    begin
        int phase;
        int start_bytes;
        int frames;
        logic [31:0] setting;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames with verbose still at its reset value
        send_frame(1, PICK_RANDOM, 0, FILL_RANDOM, 0);
        send_frame(13, PICK_IP4, 0, FILL_RANDOM, 0);
        send_frame(14, PICK_RANDOM, 0, FILL_ZERO, 0);
        send_frame(14, PICK_IP6, 0, FILL_RANDOM, 0);
        send_frame(41, PICK_ARP, 0, FILL_RANDOM, 0);
        send_frame(42, PICK_ARP, 0, FILL_RANDOM, 0);
        send_frame(64, PICK_ARP, 0, FILL_ONES, 0);
        send_frame(33, PICK_IP4, 1, FILL_RANDOM, 0);
        send_frame(38, PICK_IP4, 1, FILL_RANDOM, 0);
        send_frame(40, PICK_IP4, 1, FILL_RANDOM, 1);

        // a write to an unmapped index must leave verbose off
        wait_drained();
        write_reg(RegSpare, 32'h0000_0001);
        send_frame(38, PICK_IP4, 1, FILL_RANDOM, 0);

        // tcp port extraction
        wait_drained();
        write_reg(int'(RegVerbose), 32'h0000_0001);
        send_frame(37, PICK_IP4, 1, FILL_RANDOM, 0);
        send_frame(38, PICK_IP4, 1, FILL_RANDOM, 0);
        send_frame(34, PICK_IP4, 1, FILL_ZERO, 0);
        send_frame(50, PICK_IP4, 1, FILL_ONES, 0);
        send_frame(42, PICK_IP4, 0, FILL_ZERO, 0);
        send_frame(20, PICK_RANDOM, 0, FILL_ONES, 0);

        // random traffic under several register settings
        for (phase = 0; phase < 3; phase++)
        begin
            wait_drained();
            setting = (phase == 1) ? 32'hffff_fffe : 32'hffff_ffff;
            write_reg(int'(RegVerbose), setting);
            if (phase == 0)
                hold_off_req = 1'b1;
            start_bytes = bytes_sent;
            frames = 0;
            while (bytes_sent - start_bytes < 240 || frames < 8)
            begin
                random_frame();
                frames++;
            end
        end

        // drain, then let the pipe settle
        in_valid <= 1'b0;
        @(posedge clk);
        frames = 0;
        while (sb.pending_summaries.size() > 0 && frames < 5000)
        begin
            @(posedge clk);
            frames++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending_summaries.size() > 0)
            $error("%0d summaries never arrived", sb.pending_summaries.size());
        if (sb.errors == 0 && sb.pending_summaries.size() == 0)
            $display("ethernet_header_field_extractor test passed");
        else
            $display("ethernet_header_field_extractor test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("ethernet_header_field_extractor test failed");
        $finish;
    end

endmodule
